FILE: sv/hsvgrb_pkg.sv
// ----------------------------------------------------------------------------
// hsvgrb_pkg
// Shared constants and types for the HSV to GRB pixel converter.
// ----------------------------------------------------------------------------
package hsvgrb_pkg;

	localparam int FRAC_BITS_DEFAULT = 12;
	localparam int HUE_W = 15;
	localparam int FRAC_IN_W = 13;
	localparam int CH_W = 8;
	localparam int K_W = 12;

	// queue depths, both powers of two
	localparam int MID_DEPTH_DEFAULT = 2;
	localparam int OUT_DEPTH_DEFAULT = 8;

	localparam logic [HUE_W-1:0] HUE_FULL = 15'd23040;
	localparam logic [K_W-1:0] SECTOR_UNITS = 12'd3840;
	localparam logic [CH_W-1:0] CHANNEL_MAX = 8'd255;

	typedef logic [CH_W-1:0] chan_t;

endpackage

FILE: sv/hsvgrb_fifo.sv
// ----------------------------------------------------------------------------
// hsvgrb_fifo
// Small register-based FIFO with occupancy count. DEPTH is a power of two.
// ----------------------------------------------------------------------------
module hsvgrb_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       wr_en,
	input  logic [WIDTH-1:0]           wr_data,
	output logic                       full,
	input  logic                       rd_en,
	output logic [WIDTH-1:0]           rd_data,
	output logic                       empty,
	output logic [$clog2(DEPTH+1)-1:0] count
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH+1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic do_wr;
	logic do_rd;

	assign full = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);
	assign count = count_q;
	assign do_wr = wr_en && !full;
	assign do_rd = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + PW'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + CW'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

FILE: sv/hsvgrb_front.sv
// ----------------------------------------------------------------------------
// hsvgrb_front
// Accepts HSV items, clamps fractions, wraps hue, finds the hue sector and
// picks the per-channel saturation weight k.
// ----------------------------------------------------------------------------
module hsvgrb_front #(
	parameter int FRACTION_BITS = hsvgrb_pkg::FRAC_BITS_DEFAULT,
	parameter int ITEM_W = 3 * hsvgrb_pkg::K_W + 2 * (FRACTION_BITS + 1)
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               push,
	output logic                               full,
	input  logic [hsvgrb_pkg::HUE_W-1:0]       hue,
	input  logic [hsvgrb_pkg::FRAC_IN_W-1:0]   saturation,
	input  logic [hsvgrb_pkg::FRAC_IN_W-1:0]   brightness,
	input  logic                               q_full,
	output logic                               q_wr,
	output logic [ITEM_W-1:0]                  q_data
);
	import hsvgrb_pkg::*;

	localparam int F = FRACTION_BITS;
	localparam int XW = (F + 1 > FRAC_IN_W) ? F + 1 : FRAC_IN_W;

	// Channel value is v * (3840*one - s*k) over the common denominator:
	// k = 0 gives v, 3840 gives p, rem gives q, 3840-rem gives t.
	typedef struct packed {
		logic [K_W-1:0] k_r;
		logic [K_W-1:0] k_g;
		logic [K_W-1:0] k_b;
		logic [F:0]     sat;
		logic [F:0]     val;
	} item_t;

	localparam logic [XW-1:0] ONE_X = XW'(1) << F;

	item_t item_s1;
	item_t item_d;
	logic valid_s1;
	logic accept;
	logic [HUE_W-1:0] h_wrap;
	logic [HUE_W-1:0] h_rem;
	logic [K_W-1:0] rem;
	logic [K_W-1:0] rem_c;
	logic [XW-1:0] sat_x;
	logic [XW-1:0] bri_x;

	assign full = valid_s1 && q_full;
	assign accept = push && !full;
	assign q_wr = valid_s1 && !q_full;
	assign q_data = item_s1;

	always_comb begin
		sat_x = XW'(saturation);
		bri_x = XW'(brightness);
		item_d.sat = (sat_x > ONE_X) ? ONE_X[F:0] : sat_x[F:0];
		item_d.val = (bri_x > ONE_X) ? ONE_X[F:0] : bri_x[F:0];

		h_wrap = (hue >= HUE_FULL) ? hue - HUE_FULL : hue;
		h_rem = h_wrap;
		if (h_wrap >= HUE_W'(5 * 3840)) begin
			h_rem = h_wrap - HUE_W'(5 * 3840);
		end else if (h_wrap >= HUE_W'(4 * 3840)) begin
			h_rem = h_wrap - HUE_W'(4 * 3840);
		end else if (h_wrap >= HUE_W'(3 * 3840)) begin
			h_rem = h_wrap - HUE_W'(3 * 3840);
		end else if (h_wrap >= HUE_W'(2 * 3840)) begin
			h_rem = h_wrap - HUE_W'(2 * 3840);
		end else if (h_wrap >= HUE_W'(3840)) begin
			h_rem = h_wrap - HUE_W'(3840);
		end
		rem = h_rem[K_W-1:0];
		rem_c = SECTOR_UNITS - rem;

		// sector decode: (r,g,b) = v,t,p / q,v,p / p,v,t / p,q,v / t,p,v / v,p,q
		if (h_wrap >= HUE_W'(5 * 3840)) begin
			item_d.k_r = '0;           item_d.k_g = SECTOR_UNITS; item_d.k_b = rem;
		end else if (h_wrap >= HUE_W'(4 * 3840)) begin
			item_d.k_r = rem_c;        item_d.k_g = SECTOR_UNITS; item_d.k_b = '0;
		end else if (h_wrap >= HUE_W'(3 * 3840)) begin
			item_d.k_r = SECTOR_UNITS; item_d.k_g = rem;          item_d.k_b = '0;
		end else if (h_wrap >= HUE_W'(2 * 3840)) begin
			item_d.k_r = SECTOR_UNITS; item_d.k_g = '0;           item_d.k_b = rem_c;
		end else if (h_wrap >= HUE_W'(3840)) begin
			item_d.k_r = rem;          item_d.k_g = '0;           item_d.k_b = SECTOR_UNITS;
		end else begin
			item_d.k_r = '0;           item_d.k_g = rem_c;        item_d.k_b = SECTOR_UNITS;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (q_wr) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item_d;
		end
	end

endmodule

FILE: sv/hsvgrb_back.sv
// ----------------------------------------------------------------------------
// hsvgrb_back
// Two multiply stages and the final scale: channel = (17*v*(3840*one - s*k))
// >> (2F+8), which equals floor(255 * fraction) exactly. Issues only when
// the result queue has room for everything in flight.
// ----------------------------------------------------------------------------
module hsvgrb_back #(
	parameter int FRACTION_BITS = hsvgrb_pkg::FRAC_BITS_DEFAULT,
	parameter int ITEM_W = 3 * hsvgrb_pkg::K_W + 2 * (FRACTION_BITS + 1),
	parameter int OUT_DEPTH = hsvgrb_pkg::OUT_DEPTH_DEFAULT
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               q_empty,
	output logic                               q_rd,
	input  logic [ITEM_W-1:0]                  q_data,
	input  logic [$clog2(OUT_DEPTH+1)-1:0]     o_count,
	output logic                               o_wr,
	output logic [3*hsvgrb_pkg::CH_W-1:0]      o_data
);
	import hsvgrb_pkg::*;

	localparam int F = FRACTION_BITS;
	localparam int AW = F + K_W;
	localparam int PRW = F + 1 + AW;
	localparam int XW2 = PRW + 5;
	localparam int SHIFT = 2 * F + 8;
	localparam int CW = $clog2(OUT_DEPTH + 1);
	localparam logic [AW-1:0] FULL_A = AW'(SECTOR_UNITS) << F;

	typedef struct packed {
		logic [K_W-1:0] k_r;
		logic [K_W-1:0] k_g;
		logic [K_W-1:0] k_b;
		logic [F:0]     sat;
		logic [F:0]     val;
	} item_t;

	function automatic chan_t scale_ch(input logic [PRW-1:0] p);
		logic [XW2-1:0] x;
		logic [XW2-1:0] y;
		x = {p, 4'b0000} + XW2'(p);
		y = x >> SHIFT;
		return (y > XW2'(CHANNEL_MAX)) ? CHANNEL_MAX : y[CH_W-1:0];
	endfunction

	item_t in_item;
	logic valid_s1;
	logic valid_s2;
	logic [AW-1:0] a_r_s1;
	logic [AW-1:0] a_g_s1;
	logic [AW-1:0] a_b_s1;
	logic [F:0] val_s1;
	logic [PRW-1:0] p_r_s2;
	logic [PRW-1:0] p_g_s2;
	logic [PRW-1:0] p_b_s2;
	logic [CW:0] committed;

	assign in_item = item_t'(q_data);
	assign committed = {1'b0, o_count} + (CW+1)'(valid_s1) + (CW+1)'(valid_s2);
	assign q_rd = !q_empty && (committed < (CW+1)'(OUT_DEPTH));

	assign o_wr = valid_s2;
	assign o_data = {scale_ch(p_r_s2), scale_ch(p_g_s2), scale_ch(p_b_s2)};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= q_rd;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (q_rd) begin
			a_r_s1 <= FULL_A - AW'(in_item.sat) * AW'(in_item.k_r);
			a_g_s1 <= FULL_A - AW'(in_item.sat) * AW'(in_item.k_g);
			a_b_s1 <= FULL_A - AW'(in_item.sat) * AW'(in_item.k_b);
			val_s1 <= in_item.val;
		end
		if (valid_s1) begin
			p_r_s2 <= PRW'(val_s1) * PRW'(a_r_s1);
			p_g_s2 <= PRW'(val_s1) * PRW'(a_g_s1);
			p_b_s2 <= PRW'(val_s1) * PRW'(a_b_s1);
		end
	end

endmodule

FILE: sv/hsv_to_grb_pixel.sv
// Path: front register, mid queue, back-end stages s1 and s2, then the result queue.
// Throughput: one item per cycle, sustained while pop keeps up; the front
// register and a 2-entry queue absorb back-end stalls, the 8-entry result
// queue holds finished pixels. Back end issues only against result-queue credit.
// Reset (arst_n low): queues and stage valids clear, full low, empty high.
// ----------------------------------------------------------------------------
// hsv_to_grb_pixel
// HSV to 8-bit RGB converter with LED GRB packing, queue interface both sides.
// ----------------------------------------------------------------------------
module hsv_to_grb_pixel #(
	parameter int FRACTION_BITS = hsvgrb_pkg::FRAC_BITS_DEFAULT,
	parameter int MID_DEPTH = hsvgrb_pkg::MID_DEPTH_DEFAULT,
	parameter int OUT_DEPTH = hsvgrb_pkg::OUT_DEPTH_DEFAULT
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             push,
	output logic                             full,
	input  logic [hsvgrb_pkg::HUE_W-1:0]     hue,
	input  logic [hsvgrb_pkg::FRAC_IN_W-1:0] saturation,
	input  logic [hsvgrb_pkg::FRAC_IN_W-1:0] brightness,
	output logic                             empty,
	input  logic                             pop,
	output logic [hsvgrb_pkg::CH_W-1:0]      red,
	output logic [hsvgrb_pkg::CH_W-1:0]      green,
	output logic [hsvgrb_pkg::CH_W-1:0]      blue,
	output logic [31:0]                      packed_pixel
);
	import hsvgrb_pkg::*;

	localparam int ITEM_W = 3 * K_W + 2 * (FRACTION_BITS + 1);
	localparam int OCW = $clog2(OUT_DEPTH + 1);

	logic mid_wr;
	logic mid_full;
	logic [ITEM_W-1:0] mid_wdata;
	logic mid_rd;
	logic mid_empty;
	logic [ITEM_W-1:0] mid_rdata;
	logic [$clog2(MID_DEPTH+1)-1:0] mid_count;
	logic out_wr;
	logic [3*CH_W-1:0] out_wdata;
	logic [3*CH_W-1:0] out_rdata;
	logic out_full;
	logic [OCW-1:0] out_count;

	hsvgrb_front #(
		.FRACTION_BITS(FRACTION_BITS),
		.ITEM_W(ITEM_W)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.hue(hue),
		.saturation(saturation),
		.brightness(brightness),
		.q_full(mid_full),
		.q_wr(mid_wr),
		.q_data(mid_wdata)
	);

	hsvgrb_fifo #(
		.WIDTH(ITEM_W),
		.DEPTH(MID_DEPTH)
	) u_mid_q (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(mid_wr),
		.wr_data(mid_wdata),
		.full(mid_full),
		.rd_en(mid_rd),
		.rd_data(mid_rdata),
		.empty(mid_empty),
		.count(mid_count)
	);

	hsvgrb_back #(
		.FRACTION_BITS(FRACTION_BITS),
		.ITEM_W(ITEM_W),
		.OUT_DEPTH(OUT_DEPTH)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_empty(mid_empty),
		.q_rd(mid_rd),
		.q_data(mid_rdata),
		.o_count(out_count),
		.o_wr(out_wr),
		.o_data(out_wdata)
	);

	// out_full never blocks a write: the back end issues against credit
	hsvgrb_fifo #(
		.WIDTH(3 * CH_W),
		.DEPTH(OUT_DEPTH)
	) u_out_q (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(out_wr && !out_full),
		.wr_data(out_wdata),
		.full(out_full),
		.rd_en(pop),
		.rd_data(out_rdata),
		.empty(empty),
		.count(out_count)
	);

	assign red = out_rdata[3*CH_W-1:2*CH_W];
	assign green = out_rdata[2*CH_W-1:CH_W];
	assign blue = out_rdata[CH_W-1:0];
	assign packed_pixel = {green, red, blue, 8'h00};

	logic unused_mid_count;
	assign unused_mid_count = ^mid_count;

endmodule

FILE: sv/hsvgrb_checker.sv
// ----------------------------------------------------------------------------
// hsvgrb_checker
// Port-level checks for hsv_to_grb_pixel, attached by bind.
// ----------------------------------------------------------------------------
module hsvgrb_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        push,
	input logic        full,
	input logic        empty,
	input logic        pop,
	input logic [7:0]  red,
	input logic [7:0]  green,
	input logic [7:0]  blue,
	input logic [31:0] packed_pixel
);
	// transactions accepted but not yet popped
	logic [5:0] pending_q;
	logic in_txn;
	logic out_txn;

	assign in_txn = push && !full;
	assign out_txn = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if (in_txn && !out_txn) begin
			pending_q <= pending_q + 6'd1;
		end else if (out_txn && !in_txn) begin
			pending_q <= pending_q - 6'd1;
		end
	end

	a_packing: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> packed_pixel == {green, red, blue, 8'h00})
		else $error("packed_pixel does not match channel outputs");

	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> pending_q != 6'd0)
		else $error("result shown with no transaction outstanding");

	a_full_backlog: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> pending_q >= 6'd3)
		else $error("full asserted with too little backlog");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(packed_pixel)))
		else $error("waiting result changed or vanished");

endmodule

bind hsv_to_grb_pixel hsvgrb_checker u_hsvgrb_checker (
	.clk(clk),
	.arst_n(arst_n),
	.push(push),
	.full(full),
	.empty(empty),
	.pop(pop),
	.red(red),
	.green(green),
	.blue(blue),
	.packed_pixel(packed_pixel)
);
